FILE: hdl/mbdp_pkg.sv
package mbdp_pkg;

  localparam int SampleW = 24;
  localparam int CoefW   = 16;
  localparam int MeterW  = 14;
  localparam int MaxBands = 8;
  localparam int AmountLimit = 96;

  localparam logic [2:0] RegThreshold = 3'd0;
  localparam logic [2:0] RegAttack    = 3'd1;
  localparam logic [2:0] RegRelease   = 3'd2;
  localparam logic [2:0] RegStrength  = 3'd3;
  localparam logic [2:0] RegAmounts   = 3'd4;
  localparam logic [2:0] RegPolesLow  = 3'd5;
  localparam logic [2:0] RegPolesHigh = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture input sample and channel
    logic       split_en;  // run lowpass split idx
    logic       band_en;   // process band idx
    logic       finish;    // saturate sum, or pass sample through, into output register
    logic [2:0] idx;
  } mbdp_cmd_t;

  typedef logic [19:0] gain_t;

  function automatic logic [20:0] db_int(input logic [5:0] k);
    logic [20:0] r;
    case (k)
      6'd0: r = 21'd4135;     6'd1: r = 21'd4640;     6'd2: r = 21'd5206;
      6'd3: r = 21'd5841;     6'd4: r = 21'd6554;     6'd5: r = 21'd7353;
      6'd6: r = 21'd8250;     6'd7: r = 21'd9257;     6'd8: r = 21'd10387;
      6'd9: r = 21'd11654;    6'd10: r = 21'd13076;   6'd11: r = 21'd14672;
      6'd12: r = 21'd16462;   6'd13: r = 21'd18471;   6'd14: r = 21'd20724;
      6'd15: r = 21'd23253;   6'd16: r = 21'd26090;   6'd17: r = 21'd29274;
      6'd18: r = 21'd32846;   6'd19: r = 21'd36854;   6'd20: r = 21'd41350;
      6'd21: r = 21'd46396;   6'd22: r = 21'd52057;   6'd23: r = 21'd58409;
      6'd24: r = 21'd65536;   6'd25: r = 21'd73533;   6'd26: r = 21'd82505;
      6'd27: r = 21'd92572;   6'd28: r = 21'd103868;  6'd29: r = 21'd116541;
      6'd30: r = 21'd130762;  6'd31: r = 21'd146717;  6'd32: r = 21'd164619;
      6'd33: r = 21'd184706;  6'd34: r = 21'd207243;  6'd35: r = 21'd232531;
      6'd36: r = 21'd260904;  6'd37: r = 21'd292739;  6'd38: r = 21'd328458;
      6'd39: r = 21'd368536;  6'd40: r = 21'd413504;  6'd41: r = 21'd463959;
      6'd42: r = 21'd520571;  6'd43: r = 21'd584090;  6'd44: r = 21'd655360;
      6'd45: r = 21'd735326;  6'd46: r = 21'd825049;  6'd47: r = 21'd925721;
      default: r = 21'd1038676;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] db_frac(input logic [3:0] f);
    logic [16:0] r;
    case (f)
      4'd0: r = 17'd65536;  4'd1: r = 17'd66009;  4'd2: r = 17'd66486;
      4'd3: r = 17'd66966;  4'd4: r = 17'd67450;  4'd5: r = 17'd67937;
      4'd6: r = 17'd68427;  4'd7: r = 17'd68922;  4'd8: r = 17'd69419;
      4'd9: r = 17'd69921;  4'd10: r = 17'd70425; 4'd11: r = 17'd70934;
      4'd12: r = 17'd71446; 4'd13: r = 17'd71962; 4'd14: r = 17'd72482;
      default: r = 17'd73005;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/mbdp_in_if.sv
interface mbdp_in_if;
  logic        valid;
  logic        ready;
  logic        channel;
  logic [23:0] sample_in;
  modport source (output valid, channel, sample_in, input ready);
  modport sink   (input valid, channel, sample_in, output ready);
endinterface

FILE: hdl/mbdp_out_if.sv
interface mbdp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] sample_out;
  logic [13:0] meter_band0;
  logic [13:0] meter_band1;
  logic [13:0] meter_band2;
  logic [13:0] meter_band3;
  logic [13:0] meter_band4;
  logic [13:0] meter_band5;
  logic [13:0] meter_band6;
  logic [13:0] meter_band7;
  modport source (output valid, sample_out, meter_band0, meter_band1, meter_band2,
                  meter_band3, meter_band4, meter_band5, meter_band6, meter_band7,
                  input ready);
  modport sink   (input valid, sample_out, meter_band0, meter_band1, meter_band2,
                  meter_band3, meter_band4, meter_band5, meter_band6, meter_band7,
                  output ready);
endinterface

FILE: hdl/mbdp_ctrl.sv
module mbdp_ctrl #(
  parameter int CHANNELS = 2,
  parameter int BANDS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_channel,
  output logic                  in_ready,
  input  logic                  out_busy,
  input  logic                  band_busy,
  output mbdp_pkg::mbdp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SPLIT = 5'b00010,
    S_BAND  = 5'b00100,
    S_DONE  = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          idx_nxt  = '0;
          if (32'(in_channel) < CHANNELS) state_nxt = (BANDS > 1) ? S_SPLIT : S_BAND;
          else state_nxt = S_WAIT;
        end
      end
      S_SPLIT: begin
        cmd.split_en = 1'b1;
        if (32'(idx_r) == BANDS - 2) begin
          idx_nxt   = '0;
          state_nxt = S_BAND;
        end else idx_nxt = idx_r + 3'd1;
      end
      S_BAND: begin
        // next band only once the band sequencer is back at its first step
        if (!band_busy) begin
          cmd.band_en = 1'b1;
          if (32'(idx_r) == BANDS - 1) state_nxt = S_DONE;
          else idx_nxt = idx_r + 3'd1;
        end
      end
      S_DONE, S_WAIT: begin
        if (!out_busy && !band_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.split_en |-> 32'(cmd.idx) < BANDS - 1) else $error("split index overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_busy) else $error("finish over pending output");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.split_en, cmd.band_en, cmd.finish})) else $error("cmd clash");

endmodule

FILE: hdl/mbdp_datapath.sv
// Each band step is a short chain of registered sub-steps handled by a small
// internal sequencer: envelope, excess dB, gain and meter, scaling.
module mbdp_datapath #(
  parameter int CHANNELS = 2,
  parameter int BANDS    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbdp_pkg::mbdp_cmd_t cmd,
  output logic                busy,
  output logic                band_busy,
  input  logic                in_channel,
  input  logic signed [23:0]  in_sample,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_sample,
  output logic [8*14-1:0]     out_meters
);

  localparam int ChW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int Splits = BANDS - 1;
  localparam int SplitN = (Splits > 0) ? Splits : 1;
  localparam int SpW    = (SplitN > 1) ? $clog2(SplitN) : 1;

  logic [22:0]  thr_r;
  logic [15:0]  att_r, rel_r, str_r;
  logic [63:0]  amt_r;
  logic [111:0] poles_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 23'd2097152; att_r <= 16'd6554; rel_r <= 16'd66; str_r <= 16'd4096;
      amt_r <= '0; poles_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbdp_pkg::RegThreshold: thr_r <= cfg_data[22:0];
        mbdp_pkg::RegAttack:    att_r <= cfg_data[15:0];
        mbdp_pkg::RegRelease:   rel_r <= cfg_data[15:0];
        mbdp_pkg::RegStrength:  str_r <= cfg_data[15:0];
        mbdp_pkg::RegAmounts:   amt_r <= cfg_data;
        mbdp_pkg::RegPolesLow:  poles_r[63:0] <= cfg_data;
        mbdp_pkg::RegPolesHigh: poles_r[111:64] <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // state stores, reset to zero
  logic signed [23:0] fmem_r [SplitN][CHANNELS];
  logic        [23:0] env_r  [BANDS][CHANNELS];
  logic signed [15:0] meter_r[BANDS];

  logic               ch_r;
  logic [ChW-1:0]     chi;
  logic signed [23:0] x_r;
  logic signed [24:0] low_r [SplitN];
  logic signed [31:0] sum_r;

  assign chi = ChW'(ch_r);

  // band sub-step sequencer
  logic [2:0]  ph_r;
  logic [2:0]  bi_r;
  logic signed [25:0] bsmp_r;
  logic [24:0] mag_r;
  logic [23:0] over_r;
  logic        act_r;
  logic        neg_r;
  logic [13:0] cap_r;
  logic signed [14:0] applied_r;
  logic [43:0] prod_r;
  logic [19:0] gain_r;

  assign busy      = out_valid && !out_ready;
  assign band_busy = (ph_r != 3'd0);

  // split filter
  logic [15:0]        pole;
  logic signed [24:0] sdiff;
  logic signed [41:0] sprod;
  logic signed [24:0] ynew;
  always_comb begin
    pole  = poles_r[16*cmd.idx +: 16];
    sdiff = 25'(fmem_r[cmd.idx[SpW-1:0]][chi]) - 25'(x_r);
    sprod = $signed({1'b0, pole}) * sdiff;
    ynew  = 25'(x_r) + 25'((sprod + 42'sd32768) >>> 16);
  end

  // band value at cmd.idx
  logic signed [25:0] band_v;
  always_comb begin
    if (cmd.idx == 3'd0) band_v = 26'(low_r[0]);
    else if (32'(cmd.idx) == BANDS - 1) band_v = 26'(x_r) - 26'(low_r[SplitN-1]);
    else band_v = 26'(low_r[cmd.idx[SpW-1:0]])
                - 26'(low_r[cmd.idx[SpW-1:0] - 1'b1]);
  end

  logic [2:0] bi_c;
  assign bi_c = bi_r;
  logic signed [7:0] amt_raw;
  logic signed [7:0] amt_s;
  assign amt_raw = amt_r[8*bi_c +: 8];
  always_comb begin
    if (amt_raw > 8'sd96) amt_s = 8'sd96;
    else if (amt_raw < -8'sd96) amt_s = -8'sd96;
    else amt_s = amt_raw;
  end

  // envelope
  logic [23:0]        env_old;
  logic [15:0]        ec;
  logic signed [25:0] ediff;
  logic signed [42:0] eprod;
  logic [23:0]        env_nx;
  always_comb begin
    env_old = env_r[bi_c][chi];
    ec      = (mag_r > 25'(env_old)) ? att_r : rel_r;
    ediff   = 26'($signed({1'b0, mag_r})) - 26'($signed({1'b0, env_old}));
    eprod   = $signed({1'b0, ec}) * ediff;
    env_nx  = 24'(26'($signed({2'b0, env_old})) + 26'((eprod + 43'sd32768) >>> 16));
  end

  // excess dB: over*24*strength, rnd 27
  logic [43:0] dprod;
  logic [16:0] dval;
  assign dprod = 44'(over_r) * 44'(str_r) * 44'd24;
  assign dval  = 17'((prod_r + 44'd67108864) >> 27);

  // gain lookup
  logic signed [15:0] qsum;
  logic [10:0]        q;
  logic [5:0]         qi;
  logic [37:0]        gprod;
  always_comb begin
    qsum = (16'(applied_r) + 16'sd6152) >>> 4;
    q    = (qsum < 0) ? 11'd0 : 11'(qsum);
    qi   = (q[10:4] > 7'd48) ? 6'd48 : q[9:4];
    gprod = 38'(mbdp_pkg::db_int(qi)) * 38'(mbdp_pkg::db_frac(q[3:0]));
  end

  logic signed [46:0] sprod2;
  assign sprod2 = bsmp_r * $signed({1'b0, gain_r});

  logic signed [40:0] mprod;
  assign mprod = 41'(meter_r[bi_c]) * 41'sd56361 + 41'(applied_r) * 41'sd9175;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SplitN; s++)
        for (int c = 0; c < CHANNELS; c++) fmem_r[s][c] <= '0;
      for (int b = 0; b < BANDS; b++) begin
        meter_r[b] <= '0;
        for (int c = 0; c < CHANNELS; c++) env_r[b][c] <= '0;
      end
      ph_r <= '0; out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ch_r <= in_channel; x_r <= in_sample; sum_r <= '0;
      end
      if (cmd.split_en) begin
        fmem_r[cmd.idx[SpW-1:0]][chi] <= ynew[23:0];
        low_r[cmd.idx[SpW-1:0]] <= ynew;
      end
      case (ph_r)
        3'd0: if (cmd.band_en) begin
          bi_r <= cmd.idx; bsmp_r <= band_v;
          mag_r <= 25'((band_v < 0) ? -band_v : band_v);
          ph_r <= 3'd1;
        end
        3'd1: begin
          env_r[bi_c][chi] <= env_nx;
          act_r <= (amt_s != 0) && (env_nx > 24'(thr_r));
          over_r <= env_nx - 24'(thr_r);
          neg_r <= amt_s < 0;
          cap_r <= 14'((amt_s < 0) ? -amt_s : amt_s) * 14'd64;
          ph_r <= 3'd2;
        end
        3'd2: begin prod_r <= dprod; ph_r <= 3'd3; end
        3'd3: begin
          if (!act_r) applied_r <= '0;
          else if (dval > 17'(cap_r)) applied_r <= neg_r ? 15'(cap_r) : -15'(cap_r);
          else applied_r <= neg_r ? 15'(dval) : -15'(dval);
          ph_r <= 3'd4;
        end
        3'd4: begin
          gain_r <= 20'((gprod + 38'd32768) >> 16);
          meter_r[bi_c] <= 16'((mprod + 41'sd32768) >>> 16);
          ph_r <= 3'd5;
        end
        default: begin
          if (act_r) sum_r <= sum_r + 32'((sprod2 + 47'sd32768) >>> 16);
          else sum_r <= sum_r + 32'(bsmp_r);
          ph_r <= 3'd0;
        end
      endcase
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (32'(ch_r) >= CHANNELS) out_sample <= x_r;
        else if (sum_r > 32'sd8388607) out_sample <= 24'sd8388607;
        else if (sum_r < -32'sd8388608) out_sample <= -24'sd8388608;
        else out_sample <= sum_r[23:0];
        for (int b = 0; b < 8; b++)
          out_meters[14*b +: 14] <= (b < BANDS) ? meter_r[b % BANDS][13:0] : 14'd0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.band_en |-> ph_r == 3'd0) else $error("band step overlap");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> ph_r == 3'd0) else $error("finish before band done");

endmodule

FILE: hdl/multiband_dynamics_processor_unit.sv
// Eight-band dynamic equaliser, one sample per transaction.
// Input channel: valid/ready with channel and sample_in (Q1.23). Output channel:
// valid/ready with sample_out and eight Q6.8 dB meters.
// Configuration: cfg_we, cfg_index (register 0..6), cfg_data (64 bits), to be
// written by the user only while idle; the unit itself does not enforce this.
// Indexes beyond 6 are ignored. Each sample is loaded, split by (BANDS-1) lowpass
// steps, run band by band through the shared band sequencer and then output. One
// transaction is processed at a time; the next sample is not taken until the
// current one finishes. Channels not below CHANNELS pass samples straight through.
// Reset clears filter, envelope and meter state and loads register defaults.
// A stalled receiver holds the output register; the unit still returns to idle and
// takes the next input, but cannot finish it until the held result is gone.
module multiband_dynamics_processor_unit #(
  parameter int CHANNELS = 2,
  parameter int BANDS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mbdp_in_if.sink     in_ch,
  mbdp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  mbdp_pkg::mbdp_cmd_t cmd;
  logic                busy;
  logic                band_busy;
  logic [8*14-1:0]     meters;

  mbdp_ctrl #(.CHANNELS(CHANNELS), .BANDS(BANDS)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_channel(in_ch.channel), .in_ready(in_ch.ready),
    .out_busy(busy), .band_busy(band_busy), .cmd(cmd)
  );

  mbdp_datapath #(.CHANNELS(CHANNELS), .BANDS(BANDS)) u_dp (
    .clk, .rst_n, .cmd(cmd), .busy(busy), .band_busy(band_busy),
    .in_channel(in_ch.channel), .in_sample(in_ch.sample_in),
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_sample(out_ch.sample_out), .out_meters(meters)
  );

  assign out_ch.meter_band0 = meters[13:0];
  assign out_ch.meter_band1 = meters[27:14];
  assign out_ch.meter_band2 = meters[41:28];
  assign out_ch.meter_band3 = meters[55:42];
  assign out_ch.meter_band4 = meters[69:56];
  assign out_ch.meter_band5 = meters[83:70];
  assign out_ch.meter_band6 = meters[97:84];
  assign out_ch.meter_band7 = meters[111:98];

endmodule

FILE: bench/multiband_dynamics_processor_unit_tb.sv
module multiband_dynamics_processor_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegSpare = 3'd7;  // no register behind this index
  localparam int IdleLimit = 3000;
  localparam int DrainCycles = 80;
  localparam int Phases = 8;
  localparam int PhaseItems = 142;
  localparam int DirRows = 20;
  localparam int DirSplit = 10;

  typedef struct packed {
    logic [mbdp_pkg::SampleW-1:0]                         smp;
    logic [mbdp_pkg::MaxBands-1:0][mbdp_pkg::MeterW-1:0] mtr;
  } eq_result_t;

  typedef struct packed {
    bit                           ch;
    logic [mbdp_pkg::SampleW-1:0] s;
    bit                           typed;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  mbdp_in_if in_if();
  mbdp_out_if out_if();

  multiband_dynamics_processor_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // dB gain tables: integer dB steps from -24 dB, and 1/16 dB fractions, Q4.16 and Q1.16
  const longint db_step_lut [49] = '{
    4135, 4640, 5206, 5841, 6554, 7353, 8250, 9257, 10387, 11654, 13076, 14672,
    16462, 18471, 20724, 23253, 26090, 29274, 32846, 36854, 41350, 46396, 52057, 58409,
    65536, 73533, 82505, 92572, 103868, 116541, 130762, 146717, 164619, 184706, 207243,
    232531, 260904, 292739, 328458, 368536, 413504, 463959, 520571, 584090, 655360,
    735326, 825049, 925721, 1038676};
  const longint db_fine_lut [16] = '{
    65536, 66009, 66486, 66966, 67450, 67937, 68427, 68922,
    69419, 69921, 70425, 70934, 71446, 71962, 72482, 73005};

  // at reset the poles are zero, so every split passes the input and the output equals it
  dir_row_t dir_tab [DirRows] = '{
    '{1'b0, 24'h800000, 1'b1}, '{1'b1, 24'h7FFFFF, 1'b1}, '{1'b0, 24'h000000, 1'b1},
    '{1'b1, 24'hFFFFFF, 1'b1}, '{1'b0, 24'h000001, 1'b1}, '{1'b1, 24'h800000, 1'b1},
    '{1'b0, 24'h7FFFFF, 1'b1}, '{1'b1, 24'h555555, 1'b1}, '{1'b0, 24'hAAAAAA, 1'b1},
    '{1'b1, 24'h000000, 1'b1},
    '{1'b0, 24'h7FFFFF, 1'b0}, '{1'b0, 24'h7FFFFF, 1'b0}, '{1'b1, 24'h800000, 1'b0},
    '{1'b1, 24'h800000, 1'b0}, '{1'b0, 24'h800000, 1'b0}, '{1'b0, 24'h7FFFFF, 1'b0},
    '{1'b1, 24'h400000, 1'b0}, '{1'b0, 24'h000000, 1'b0}, '{1'b1, 24'hC00000, 1'b0},
    '{1'b0, 24'h7FFFFF, 1'b0}};

  // predictor copy of registers and state
  bit [22:0] thr_q;
  bit [15:0] atk_q, rel_q, str_q;
  bit [63:0] amt_q, pole_lo_q;
  bit [47:0] pole_hi_q;
  longint split_mem [7][2];
  longint env_lvl [8][2];
  longint meter_db [8];

  eq_result_t expected_q [$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_sat = 0;
  bit long_hold = 0;

  function automatic longint round_shr(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint db_to_lin(longint db);
    longint q, idx;
    q = (db + 6144 + 8) >>> 4;
    if (q < 0) q = 0;
    idx = q >>> 4;
    if (idx > 48) idx = 48;
    return (db_step_lut[idx] * db_fine_lut[q & 15] + 32768) >>> 16;
  endfunction

  function automatic longint pole_at(int i);
    if (i < 4) return longint'(pole_lo_q[16*i +: 16]);
    return longint'(pole_hi_q[16*(i-4) +: 16]);
  endfunction

  function automatic eq_result_t equalise(bit ch, logic [mbdp_pkg::SampleW-1:0] s);
    longint x, sum, smp, mag, env, c, amt, applied, over, d, cap;
    longint low [7];
    longint band [8];
    eq_result_t r;
    x = longint'($signed(s));
    sum = 0;
    for (int i = 0; i < 7; i++) begin
      low[i] = x + round_shr(pole_at(i) * (split_mem[i][ch] - x), 16);
      split_mem[i][ch] = low[i];
    end
    band[0] = low[0];
    for (int i = 1; i < 7; i++) band[i] = low[i] - low[i-1];
    band[7] = x - low[6];
    for (int i = 0; i < 8; i++) begin
      smp = band[i];
      mag = smp < 0 ? -smp : smp;
      env = env_lvl[i][ch];
      c = (mag > env) ? longint'(atk_q) : longint'(rel_q);
      env += round_shr(c * (mag - env), 16);
      env_lvl[i][ch] = env;
      amt = longint'($signed(amt_q[8*i +: 8]));
      if (amt > mbdp_pkg::AmountLimit) amt = mbdp_pkg::AmountLimit;
      if (amt < -mbdp_pkg::AmountLimit) amt = -mbdp_pkg::AmountLimit;
      applied = 0;
      if (amt != 0 && env > longint'(thr_q)) begin
        over = env - longint'(thr_q);
        d = (over * 24 * longint'(str_q) + (longint'(1) << 26)) >>> 27;
        cap = (amt < 0 ? -amt : amt) * 64;
        if (d > cap) d = cap;
        applied = (amt > 0) ? -d : d;
        smp = round_shr(smp * db_to_lin(applied), 16);
      end
      meter_db[i] = round_shr(meter_db[i] * 56361 + applied * 9175, 16);
      r.mtr[i] = meter_db[i][mbdp_pkg::MeterW-1:0];
      sum += smp;
    end
    if (sum > 8388607 || sum < -8388608) n_sat++;
    if (sum > 8388607) sum = 8388607;
    if (sum < -8388608) sum = -8388608;
    r.smp = sum[mbdp_pkg::SampleW-1:0];
    return r;
  endfunction

  // drives one write; the caller lowers cfg_we after its last write
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      mbdp_pkg::RegThreshold: thr_q = val[22:0];
      mbdp_pkg::RegAttack:    atk_q = val[15:0];
      mbdp_pkg::RegRelease:   rel_q = val[15:0];
      mbdp_pkg::RegStrength:  str_q = val[15:0];
      mbdp_pkg::RegAmounts:   amt_q = val;
      mbdp_pkg::RegPolesLow:  pole_lo_q = val;
      mbdp_pkg::RegPolesHigh: pole_hi_q = val[47:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    wait (expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pole();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'h8000, 16'hFF80));
    endcase
  endfunction

  // mode 0: lows, mode 1: highs but a random threshold, otherwise random; amounts and poles are random in every mode
  task automatic load_settings(int mode);
    logic [63:0] amts;
    for (int b = 0; b < 8; b++) begin
      case ($urandom_range(0, 4))
        0: amts[8*b +: 8] = 8'h00;
        1: amts[8*b +: 8] = ($urandom_range(0, 1)) ? 8'h7F : 8'h80;
        default: amts[8*b +: 8] = 8'($urandom);
      endcase
    end
    write_reg(mbdp_pkg::RegThreshold, mode == 0 ? 64'd0 : mode == 1 ? {$urandom, $urandom} :
              {$urandom, 9'd0, 23'($urandom_range(0, 1 << 21))});
    write_reg(mbdp_pkg::RegAttack, mode == 0 ? 64'd0 : mode == 1 ? 64'hFFFF : 64'($urandom));
    write_reg(mbdp_pkg::RegRelease, mode == 0 ? 64'd0 : mode == 1 ? 64'hFFFF : 64'($urandom));
    write_reg(mbdp_pkg::RegStrength, mode == 0 ? 64'd0 : mode == 1 ? 64'hFFFF : 64'($urandom));
    write_reg(mbdp_pkg::RegAmounts, amts);
    write_reg(mbdp_pkg::RegPolesLow, {pick_pole(), pick_pole(), pick_pole(), pick_pole()});
    write_reg(mbdp_pkg::RegPolesHigh, {16'($urandom), pick_pole(), pick_pole(), pick_pole()});
    write_reg(RegSpare, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // offers one sample; valid is left high for the caller to lower on a gap
  task automatic offer(bit ch, logic [mbdp_pkg::SampleW-1:0] s, bit typed);
    eq_result_t p;
    in_if.valid <= 1'b1;
    in_if.channel <= ch;
    in_if.sample_in <= s;
    do @(posedge clk); while (!in_if.ready);
    p = equalise(ch, s);
    if (typed) begin
      p.smp = s;
      p.mtr = '0;
    end
    expected_q.push_back(p);
    n_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: stalls in a pattern that is re-chosen at random whenever its counter wraps
  initial begin
    int mode;
    int cnt;
    out_if.ready = 1'b0;
    mode = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      if (cnt == 0) mode = $urandom_range(0, 3);
      cnt = (cnt + 1) % 32;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // result check
  always @(posedge clk) begin
    eq_result_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.smp = out_if.sample_out;
      got.mtr = {out_if.meter_band7, out_if.meter_band6, out_if.meter_band5,
                 out_if.meter_band4, out_if.meter_band3, out_if.meter_band2,
                 out_if.meter_band1, out_if.meter_band0};
      n_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sample_out %h", $time, got.smp);
      end else begin
        want = expected_q.pop_front();
        if (got.smp !== want.smp) begin
          errors++;
          $display("%0t: sample_out expected %h actual %h", $time, want.smp, got.smp);
        end
        for (int b = 0; b < 8; b++)
          if (got.mtr[b] !== want.mtr[b]) begin
            errors++;
            $display("%0t: meter_band%0d expected %h actual %h", $time, b,
                     want.mtr[b], got.mtr[b]);
          end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("multiband_dynamics_processor_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [mbdp_pkg::SampleW-1:0] s;
    int burst;
    in_if.valid = 1'b0;
    in_if.channel = 1'b0;
    in_if.sample_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    thr_q = 23'd2097152;
    atk_q = 16'd6554;
    rel_q = 16'd66;
    str_q = 16'd4096;
    amt_q = '0;
    pole_lo_q = '0;
    pole_hi_q = '0;
    foreach (split_mem[i, c]) split_mem[i][c] = 0;
    foreach (env_lvl[i, c]) env_lvl[i][c] = 0;
    foreach (meter_db[i]) meter_db[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DirRows; r++) begin
      if (r == DirSplit) begin
        in_if.valid <= 1'b0;
        wait_idle();
        // strong cut/boost with light threshold: saturation and amount clamping
        write_reg(mbdp_pkg::RegThreshold, 64'd1000);
        write_reg(mbdp_pkg::RegStrength, 64'hFFFF);
        write_reg(mbdp_pkg::RegAttack, 64'hFFFF);
        write_reg(mbdp_pkg::RegAmounts, 64'h80_7F_A0_60_00_01_FF_81);
        write_reg(mbdp_pkg::RegPolesLow, 64'h4000_8000_C000_F000);
        write_reg(mbdp_pkg::RegPolesHigh, 64'h1000_2000_3000);
        cfg_we <= 1'b0;
      end
      offer(dir_tab[r].ch, dir_tab[r].s, dir_tab[r].typed);
    end
    in_if.valid <= 1'b0;

    for (int ph = 0; ph < Phases; ph++) begin
      wait_idle();
      load_settings(ph < 2 ? ph : 2);
      for (int k = 0; k < PhaseItems; ) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst && k < PhaseItems; j++, k++) begin
          case ($urandom_range(0, 9))
            0: s = ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
            1, 2, 3: s = 24'($urandom);
            default: s = 24'($signed(24'($urandom)) >>> $urandom_range(1, 12));
          endcase
          offer($urandom_range(0, 1), s, 1'b0);
          if (ph == 2 && k == 20) long_hold = 1;
        end
        if (ph == 4 && k >= 60 && k < 60 + burst) begin
          in_if.valid <= 1'b0;
          wait (expected_q.size() == 0);
          @(posedge clk);
        end else if ($urandom_range(0, 2) != 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 150)) @(posedge clk);
        end
      end
      in_if.valid <= 1'b0;
    end

    wait (expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d samples over %0d register settings, %0d results checked,",
             n_sent, Phases + 2, n_seen);
    $display("including %0d saturated sums and one long receiver stall.", n_sat);
    if (errors == 0) begin
      $display("multiband_dynamics_processor_unit_tb: clean");
    end else begin
      $display("multiband_dynamics_processor_unit_tb: errors");
    end
    $finish;
  end

endmodule

FILE: multiband_dynamics_processor_unit.f
hdl/mbdp_pkg.sv
hdl/mbdp_in_if.sv
hdl/mbdp_out_if.sv
hdl/mbdp_ctrl.sv
hdl/mbdp_datapath.sv
hdl/multiband_dynamics_processor_unit.sv
bench/multiband_dynamics_processor_unit_tb.sv
